>>> hdl/pid_aw_pkg.sv
// Shared types, codes and defaults for the anti-windup PID controller.
package pid_aw_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int MUL_CHUNK      = 16;
  localparam int OP_W           = 3;
  localparam int CFG_IDX_W      = 3;

  typedef logic [OP_W-1:0]      op_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam op_t OP_P   = 3'd0;
  localparam op_t OP_KD  = 3'd1;
  localparam op_t OP_DIV = 3'd2;
  localparam op_t OP_KI  = 3'd3;
  localparam op_t OP_TS  = 3'd4;
  localparam op_t OP_KW  = 3'd5;

  localparam cfg_idx_t REG_PROP_GAIN     = 3'd0;
  localparam cfg_idx_t REG_INTEG_GAIN    = 3'd1;
  localparam cfg_idx_t REG_DERIV_GAIN    = 3'd2;
  localparam cfg_idx_t REG_SAMPLE_PERIOD = 3'd3;
  localparam cfg_idx_t REG_CLAMP_ENABLE  = 3'd4;
  localparam cfg_idx_t REG_CLAMP_LIMIT   = 3'd5;
  localparam cfg_idx_t REG_WINDUP_GAIN   = 3'd6;

  typedef struct packed {
    logic accept;
    logic clear;
    logic prep;
    logic start;
    logic commit;
    logic sum;
    logic clamp;
    logic out_load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } sts_t;

endpackage

>>> hdl/pid_controller_anti_windup_core.sv
// Top level of the fixed-point PID controller with back-calculation anti-windup.
//
// Each request on the in_ channel carries one signed error sample in in_tdata and
// an operation flag in in_tuser: 0 computes a new drive value, 1 clears the
// integral, the last error and the windup correction and returns a zero drive.
// Every request yields exactly one result on the out_ channel: the drive value in
// out_tdata and, in out_tuser, a flag that is set when the output clamp limited it.
// The user writes gains, sample period, clamp enable and limit on the cfg_ channel
// only while no request is in flight; the block does not enforce it. cfg_ready is
// always high. A compute request runs through one shared multiply/divide unit:
// five multiplies, each stepping through the gain in CH chunks of 16 bits (CH =
// DATA_WIDTH / 16 rounded up), and one restoring division that yields
// DATA_WIDTH + FRAC_BITS quotient bits, one quotient bit a cycle. The result
// register loads after the last multiply, once any held result has been taken;
// a clear request skips the arithmetic and goes straight to that load.
// The next request is accepted in the cycle after the result register loads.
// A held result stays in the output register while the block accepts and works
// on the next request; only the load of the following result waits for it.
// Reset restores the default gains and zeroes the controller state.
module pid_controller_anti_windup_core #(
  parameter int DATA_WIDTH = pid_aw_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pid_aw_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]       in_tdata,   // error_sample
  input  logic                                  in_tuser,   // operation
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]       out_tdata,  // drive
  output logic                                  out_tuser,  // clamped
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pid_aw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [DATA_WIDTH-2:0]                 cfg_data
);
  import pid_aw_pkg::*;

  localparam int TD_W = ((DATA_WIDTH + 7) / 8) * 8;

  cmd_t                  cmd;
  sts_t                  sts;
  logic [DATA_WIDTH-1:0] drive;

  pid_aw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .sts        (sts)
  );

  pid_aw_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_error    (in_tdata[DATA_WIDTH-1:0]),
    .cmd         (cmd),
    .sts         (sts),
    .out_drive   (drive),
    .out_clamped (out_tuser)
  );

  assign out_tdata = TD_W'(drive);

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> sts.busy)
    else $error("arithmetic unit did not go busy after start");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !sts.busy)
    else $error("request accepted while arithmetic unit busy");

  a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !sts.busy)
    else $error("result committed before arithmetic unit finished");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("output register loaded without raising valid");

endmodule

>>> hdl/pid_aw_ctrl.sv
// Control state machine that sequences the PID datapath for each request.
module pid_aw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tuser,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  output pid_aw_pkg::cmd_t  cmd,
  input  pid_aw_pkg::sts_t  sts
);
  import pid_aw_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_ISSUE = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_CLAMP = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  op_t        op_r, op_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op    = op_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          cmd.clear  = in_tuser;
          state_nxt  = in_tuser ? S_DONE : S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        op_nxt    = OP_P;
        state_nxt = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!sts.busy) begin
          cmd.commit = 1'b1;
          if (op_r == OP_TS) begin
            state_nxt = S_SUM;
          end else if (op_r == OP_KW) begin
            state_nxt = S_DONE;
          end else begin
            op_nxt    = op_r + 1'b1;
            state_nxt = S_ISSUE;
          end
        end
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        op_nxt    = OP_KW;
        state_nxt = S_ISSUE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_P;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> hdl/pid_aw_datapath.sv
// Datapath: gain registers, controller state, shared multiply/divide unit and clamp.
module pid_aw_datapath #(
  parameter int DATA_WIDTH = pid_aw_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = pid_aw_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pid_aw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_WIDTH-2:0]         cfg_data,
  input  logic [DATA_WIDTH-1:0]         in_error,
  input  pid_aw_pkg::cmd_t              cmd,
  output pid_aw_pkg::sts_t              sts,
  output logic [DATA_WIDTH-1:0]         out_drive,
  output logic                          out_clamped
);
  import pid_aw_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int GW    = DATA_WIDTH - 1;
  localparam int NB    = DATA_WIDTH + FRAC_BITS;
  localparam int CH    = (DATA_WIDTH + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int BW    = CH * MUL_CHUNK;
  localparam int PW    = DATA_WIDTH + BW;
  localparam int MW    = (PW > NB) ? PW : NB;
  localparam int CNT_W = $clog2(NB + 1);

  localparam logic [GW-1:0] ONE_G  = GW'(64'd1 << FRAC_BITS);
  localparam logic [GW-1:0] TS_RST = GW'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

  localparam logic [DW-1:0] VMAX_D = {1'b0, {GW{1'b1}}};
  localparam logic [DW-1:0] VMIN_D = {1'b1, {GW{1'b0}}};
  localparam logic signed [DW+1:0] VMAX_X = {3'b000, {GW{1'b1}}};
  localparam logic signed [DW+1:0] VMIN_X = {3'b111, {GW{1'b0}}};
  localparam logic [MW-1:0] NEG_LIM = {{(MW-DW){1'b0}}, 1'b1, {GW{1'b0}}};
  localparam logic [MW-1:0] POS_LIM = NEG_LIM - 1'b1;

  function automatic logic [DW-1:0] sat_x(input logic signed [DW+1:0] v);
    logic [DW-1:0] r;
    if (v > VMAX_X) begin
      r = VMAX_D;
    end else if (v < VMIN_X) begin
      r = VMIN_D;
    end else begin
      r = v[DW-1:0];
    end
    return r;
  endfunction

  logic [GW-1:0] kp_r, ki_r, kd_r, ts_r, kw_r, lim_r;
  logic          clamp_en_r;

  logic [DW-1:0] err_r, d_r, e_r, t_r, p_r, dt_r, sum_r, drive_r, diff_r;
  logic [DW-1:0] acc_r, last_r, excess_r;
  logic          clamped_r;
  logic [DW-1:0] out_drive_r;
  logic          out_clamped_r;

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic [DW-1:0]    a_r;
  logic [BW-1:0]    b_r;
  logic [PW-1:0]    prod_r;
  logic [GW-1:0]    rem_r;
  logic [NB-1:0]    qd_r;

  logic [DW-1:0]           x_sel, x_mag;
  logic [GW-1:0]           g_sel, den;
  logic [DW+MUL_CHUNK-1:0] pp;
  logic [PW-1:0]           prod_nxt;
  logic [DW-1:0]           rem2, rem_sub;
  logic                    ge;
  logic [GW-1:0]           rem_nxt;
  logic [MW-1:0]           res_mag;
  logic [DW-1:0]           res_low, res;
  logic [DW-1:0]           d_calc, e_calc, acc_upd, sum_calc;
  logic signed [DW:0]      sum_x, lim_x, neg_lim_x, dif_hi, dif_lo;
  logic                    over_hi, over_lo;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r       <= ONE_G;
      ki_r       <= '0;
      kd_r       <= '0;
      ts_r       <= TS_RST;
      clamp_en_r <= 1'b0;
      lim_r      <= '0;
      kw_r       <= ONE_G;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PROP_GAIN:     kp_r       <= cfg_data;
        REG_INTEG_GAIN:    ki_r       <= cfg_data;
        REG_DERIV_GAIN:    kd_r       <= cfg_data;
        REG_SAMPLE_PERIOD: ts_r       <= cfg_data;
        REG_CLAMP_ENABLE:  clamp_en_r <= cfg_data[0];
        REG_CLAMP_LIMIT:   lim_r      <= cfg_data;
        REG_WINDUP_GAIN:   kw_r       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    x_sel = '0;
    g_sel = '0;
    case (cmd.op)
      OP_P: begin
        x_sel = err_r;
        g_sel = kp_r;
      end
      OP_KD: begin
        x_sel = d_r;
        g_sel = kd_r;
      end
      OP_DIV: x_sel = t_r;
      OP_KI: begin
        x_sel = e_r;
        g_sel = ki_r;
      end
      OP_TS: begin
        x_sel = t_r;
        g_sel = ts_r;
      end
      OP_KW: begin
        x_sel = diff_r;
        g_sel = kw_r;
      end
      default: ;
    endcase
  end

  assign x_mag    = x_sel[DW-1] ? (~x_sel + 1'b1) : x_sel;
  assign den      = (ts_r == '0) ? GW'(1) : ts_r;
  assign pp       = a_r * b_r[BW-1 -: MUL_CHUNK];
  assign prod_nxt = (prod_r << MUL_CHUNK) + PW'(pp);
  assign rem2     = {rem_r, qd_r[NB-1]};
  assign ge       = rem2 >= {1'b0, den};
  assign rem_sub  = rem2 - {1'b0, den};
  assign rem_nxt  = ge ? rem_sub[GW-1:0] : rem2[GW-1:0];

  assign res_mag = (cmd.op == OP_DIV) ? MW'(qd_r) : MW'(prod_r >> FRAC_BITS);
  assign res_low = res_mag[DW-1:0];

  always_comb begin
    if (neg_r) begin
      res = (res_mag > NEG_LIM) ? VMIN_D : (~res_low + 1'b1);
    end else begin
      res = (res_mag > POS_LIM) ? VMAX_D : res_low;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      cnt_r  <= (cmd.op == OP_DIV) ? CNT_W'(NB) : CNT_W'(CH);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      neg_r  <= x_sel[DW-1];
      a_r    <= x_mag;
      b_r    <= BW'(g_sel);
      prod_r <= '0;
      rem_r  <= '0;
      qd_r   <= {x_mag, {FRAC_BITS{1'b0}}};
    end else if (busy_r) begin
      if (cmd.op == OP_DIV) begin
        rem_r <= rem_nxt;
        qd_r  <= {qd_r[NB-2:0], ge};
      end else begin
        prod_r <= prod_nxt;
        b_r    <= b_r << MUL_CHUNK;
      end
    end
  end

  assign sts.busy = busy_r;

  assign d_calc   = sat_x({{2{err_r[DW-1]}}, err_r} - {{2{last_r[DW-1]}}, last_r});
  assign e_calc   = clamp_en_r ?
                    sat_x({{2{err_r[DW-1]}}, err_r} - {{2{excess_r[DW-1]}}, excess_r}) :
                    err_r;
  assign acc_upd  = sat_x({{2{acc_r[DW-1]}}, acc_r} + {{2{res[DW-1]}}, res});
  assign sum_calc = sat_x({{2{p_r[DW-1]}}, p_r} + {{2{acc_r[DW-1]}}, acc_r}
                          + {{2{dt_r[DW-1]}}, dt_r});

  assign sum_x     = {sum_r[DW-1], sum_r};
  assign lim_x     = {2'b00, lim_r};
  assign neg_lim_x = -lim_x;
  assign over_hi   = sum_x > lim_x;
  assign over_lo   = sum_x < neg_lim_x;
  assign dif_hi    = sum_x - lim_x;
  assign dif_lo    = sum_x + lim_x;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      last_r   <= '0;
      excess_r <= '0;
    end else begin
      if (cmd.accept && cmd.clear) begin
        acc_r    <= '0;
        last_r   <= '0;
        excess_r <= '0;
      end
      if (cmd.sum) begin
        last_r <= err_r;
      end
      if (cmd.commit) begin
        case (cmd.op)
          OP_TS:   acc_r    <= acc_upd;
          OP_KW:   excess_r <= res;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      err_r <= in_error;
    end
    if (cmd.accept && cmd.clear) begin
      drive_r   <= '0;
      clamped_r <= 1'b0;
    end
    if (cmd.prep) begin
      d_r <= d_calc;
      e_r <= e_calc;
    end
    if (cmd.commit) begin
      case (cmd.op) inside
        OP_P:         p_r  <= res;
        OP_KD, OP_KI: t_r  <= res;
        OP_DIV:       dt_r <= res;
        default: ;
      endcase
    end
    if (cmd.sum) begin
      sum_r <= sum_calc;
    end
    if (cmd.clamp) begin
      if (clamp_en_r && over_hi) begin
        drive_r   <= lim_x[DW-1:0];
        diff_r    <= dif_hi[DW-1:0];
        clamped_r <= 1'b1;
      end else if (clamp_en_r && over_lo) begin
        drive_r   <= neg_lim_x[DW-1:0];
        diff_r    <= dif_lo[DW-1:0];
        clamped_r <= 1'b1;
      end else begin
        drive_r   <= sum_r;
        diff_r    <= '0;
        clamped_r <= 1'b0;
      end
    end
    if (cmd.out_load) begin
      out_drive_r   <= drive_r;
      out_clamped_r <= clamped_r;
    end
  end

  assign out_drive   = out_drive_r;
  assign out_clamped = out_clamped_r;

endmodule

>>> tb/pid_controller_anti_windup_core_test.sv
// Self-checking testbench for the anti-windup PID controller core.
`timescale 1ns / 1ps

module pid_controller_anti_windup_core_test;
  import pid_aw_pkg::*;

  localparam int DW = DATA_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int TDW = ((DW + 7) / 8) * 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_PAUSE = 100;
  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam logic [30:0] GAIN_MAX = 31'h7FFF_FFFF;
  localparam logic [30:0] Q_ONE = 31'h0001_0000;
  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;
  localparam cfg_idx_t REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [DW-1:0] drive;
    logic          clamped;
  } drive_result_t;

  typedef struct packed {
    logic [30:0] prop;
    logic [30:0] integ;
    logic [30:0] deriv;
    logic [30:0] period;
    logic        clamp_on;
    logic [30:0] limit;
    logic [30:0] windup;
  } pid_settings_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_tvalid = 1'b0;
  logic           in_tready;
  logic [TDW-1:0] in_tdata = '0;
  logic           in_tuser = OP_COMPUTE;
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [TDW-1:0] out_tdata;
  logic           out_tuser;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  cfg_idx_t       cfg_index = REG_PROP_GAIN;
  logic [DW-2:0]  cfg_data = '0;

  drive_result_t drive_expect_q[$];
  int error_count = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  longint kp = 65536, ki = 0, kd = 0, ts = 6554, clamp_lim = 0, kw = 65536;
  logic   clamp_en = 1'b0;
  longint integ_sum = 0, prev_error = 0, windup_corr = 0;

  pid_controller_anti_windup_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic longint sat32(input longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint signed_limit(input bit neg, input logic [127:0] m);
    if (neg) return (m > 128'd2147483648) ? VMIN : -longint'(m[63:0]);
    return (m > 128'd2147483647) ? VMAX : longint'(m[63:0]);
  endfunction

  function automatic longint q_mul(input longint a, input longint b);
    logic [127:0] ua, ub;
    bit neg;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    return signed_limit(neg, (ua * ub) >> FB);
  endfunction

  function automatic longint q_div(input longint a, input longint den);
    logic [127:0] ua, dv;
    ua = (a < 0) ? -a : a;
    dv = (den == 0) ? 128'd1 : den;
    return signed_limit(a < 0, (ua << FB) / dv);
  endfunction

  function automatic drive_result_t predict_drive(input logic op, input logic [DW-1:0] sample);
    longint err, delta, p_term, d_term, e, sum, drive;
    drive_result_t r;
    r = '0;
    if (op == OP_CLEAR) begin
      integ_sum = 0;
      prev_error = 0;
      windup_corr = 0;
      return r;
    end
    err = $signed(sample);
    delta = sat32(err - prev_error);
    p_term = q_mul(err, kp);
    d_term = q_div(q_mul(kd, delta), ts);
    e = clamp_en ? sat32(err - windup_corr) : err;
    integ_sum = sat32(integ_sum + q_mul(q_mul(e, ki), ts));
    sum = sat32(p_term + integ_sum + d_term);
    drive = sum;
    if (clamp_en) begin
      if (sum > clamp_lim) begin
        drive = clamp_lim;
        r.clamped = 1'b1;
      end else if (sum < -clamp_lim) begin
        drive = -clamp_lim;
        r.clamped = 1'b1;
      end
    end
    windup_corr = q_mul(sum - drive, kw);
    prev_error = err;
    r.drive = drive[DW-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    drive_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:     kp = cfg_data;
          REG_INTEG_GAIN:    ki = cfg_data;
          REG_DERIV_GAIN:    kd = cfg_data;
          REG_SAMPLE_PERIOD: ts = cfg_data;
          REG_CLAMP_ENABLE:  clamp_en = cfg_data[0];
          REG_CLAMP_LIMIT:   clamp_lim = cfg_data;
          REG_WINDUP_GAIN:   kw = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        drive_expect_q.push_back(predict_drive(in_tuser, in_tdata[DW-1:0]));
      end
      if (out_tvalid && out_tready) begin
        if (drive_expect_q.size() == 0) begin
          $error("unexpected result: drive %h clamped %b", out_tdata, out_tuser);
          error_count++;
        end else begin
          want = drive_expect_q.pop_front();
          if (out_tdata[DW-1:0] !== want.drive) begin
            $error("drive mismatch: expected %h, actual %h", want.drive, out_tdata[DW-1:0]);
            error_count++;
          end
          if (out_tuser !== want.clamped) begin
            $error("clamped mismatch: expected %b, actual %b", want.clamped, out_tuser);
            error_count++;
          end
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_request(input logic op, input logic [DW-1:0] sample);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= TDW'(sample);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (drive_expect_q.size() != 0);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [DW-2:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_settings(input pid_settings_t s);
    wait_drained();
    write_reg(REG_PROP_GAIN, s.prop);
    write_reg(REG_INTEG_GAIN, s.integ);
    write_reg(REG_DERIV_GAIN, s.deriv);
    write_reg(REG_SAMPLE_PERIOD, s.period);
    write_reg(REG_CLAMP_ENABLE, {30'($urandom), s.clamp_on});
    write_reg(REG_CLAMP_LIMIT, s.limit);
    write_reg(REG_WINDUP_GAIN, s.windup);
    if ($urandom_range(3) == 0) write_reg(REG_UNUSED, 31'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic pid_settings_t settings(input logic [30:0] prop, integ, deriv, period,
                                             input logic clamp_on,
                                             input logic [30:0] limit, windup);
    pid_settings_t s;
    s.prop = prop;
    s.integ = integ;
    s.deriv = deriv;
    s.period = period;
    s.clamp_on = clamp_on;
    s.limit = limit;
    s.windup = windup;
    return s;
  endfunction

  function automatic logic [30:0] rand_gain();
    case ($urandom_range(7))
      0: return '0;
      1: return GAIN_MAX;
      2: return 31'($urandom);
      default: return 31'($urandom_range(0, 1 << 18));
    endcase
  endfunction

  function automatic pid_settings_t rand_settings();
    pid_settings_t s;
    s.prop = rand_gain();
    s.integ = rand_gain();
    s.deriv = rand_gain();
    case ($urandom_range(9))
      0: s.period = '0;
      1: s.period = GAIN_MAX;
      2: s.period = 31'($urandom);
      default: s.period = 31'($urandom_range(1, 1 << 16));
    endcase
    s.clamp_on = ($urandom_range(3) != 0);
    case ($urandom_range(7))
      0: s.limit = '0;
      1: s.limit = GAIN_MAX;
      2: s.limit = 31'($urandom);
      default: s.limit = 31'($urandom_range(0, 1 << 22));
    endcase
    s.windup = rand_gain();
    return s;
  endfunction

  function automatic logic [DW-1:0] rand_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    endcase
  endfunction

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic test_reset_defaults();
    send_request(OP_COMPUTE, 32'h0001_0000);
    send_request(OP_COMPUTE, 32'hFFFF_0000);
    send_request(OP_COMPUTE, 32'h7FFF_FFFF);
    send_request(OP_COMPUTE, 32'h8000_0000);
    send_request(OP_CLEAR, 32'h7FFF_FFFF);
  endtask

  task automatic test_derivative_extremes();
    program_settings(settings('0, '0, GAIN_MAX, '0, 1'b0, '0, Q_ONE));
    send_request(OP_COMPUTE, 32'h7FFF_FFFF);
    send_request(OP_COMPUTE, 32'h8000_0000);
    send_request(OP_COMPUTE, 32'h0000_0001);
    program_settings(settings(GAIN_MAX, GAIN_MAX, Q_ONE, GAIN_MAX, 1'b0, '0, GAIN_MAX));
    send_request(OP_COMPUTE, 32'h8000_0000);
    send_request(OP_COMPUTE, 32'h0000_0000);
    send_request(OP_COMPUTE, 32'h7FFF_FFFF);
  endtask

  task automatic test_clamp_windup();
    program_settings(settings(Q_ONE, 31'h0000_8000, '0, Q_ONE, 1'b1, '0, Q_ONE));
    send_request(OP_COMPUTE, 32'h0003_0000);
    send_request(OP_COMPUTE, 32'hFFFD_0000);
    send_request(OP_COMPUTE, 32'h0000_0000);
    program_settings(settings(GAIN_MAX, Q_ONE, '0, Q_ONE, 1'b1, 31'h0002_0000, GAIN_MAX));
    send_request(OP_COMPUTE, 32'h0010_0000);
    send_request(OP_COMPUTE, 32'hFFF0_0000);
    send_request(OP_CLEAR, 32'h0000_0000);
    program_settings(settings(Q_ONE, Q_ONE, '0, Q_ONE, 1'b1, GAIN_MAX, Q_ONE));
    send_request(OP_COMPUTE, 32'h7FFF_FFFF);
    program_settings(settings(Q_ONE, Q_ONE, '0, Q_ONE, 1'b0, 31'h0001_0000, Q_ONE));
    send_request(OP_COMPUTE, 32'h0005_0000);
  endtask

  task automatic test_random_traffic(input int n_settings);
    int n_items;
    for (int k = 0; k < n_settings; k++) begin
      program_settings(rand_settings());
      n_items = $urandom_range(40, 75);
      for (int i = 0; i < n_items; i++) begin
        send_request(($urandom_range(24) == 0) ? OP_CLEAR : OP_COMPUTE, rand_sample());
        if ($urandom_range(49) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_idling(16, 83);
    test_reset_defaults();
    test_derivative_extremes();
    test_clamp_windup();
    test_random_traffic(8);
    set_idling(83, 16);
    test_random_traffic(8);
    set_idling(0, 0);
    test_random_traffic(8);
    wait_drained();
    repeat (END_PAUSE) @(posedge clk);
    if (error_count == 0 && drive_expect_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
